[sv/tgd_pkg.sv]
// Shared types, widths and codes of the touch gesture detector.
package tgd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int TIME_BITS     = 32;
    localparam int DUR_BITS      = 16;
    localparam int SQ_BITS       = 2 * COORD_BITS + 1;
    localparam int LP_SQ_BITS    = 2 * COORD_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((TIME_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM_EDGE_Y   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SWIPE_DIST  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SWIPE_DUR   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LP_MAX_MOVE     = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LP_DURATION     = CFG_IDX_BITS'(4);

    localparam logic [COORD_BITS-1:0] RST_BOTTOM_EDGE_Y  = COORD_BITS'(3900);
    localparam logic [COORD_BITS-1:0] RST_MIN_SWIPE_DIST = COORD_BITS'(400);
    localparam logic [DUR_BITS-1:0]   RST_MAX_SWIPE_DUR  = DUR_BITS'(600);
    localparam logic [COORD_BITS-1:0] RST_LP_MAX_MOVE    = COORD_BITS'(40);
    localparam logic [DUR_BITS-1:0]   RST_LP_DURATION    = DUR_BITS'(800);

    typedef enum logic [1:0] {
        CMD_DOWN = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_UP   = 2'd2,
        CMD_POLL = 2'd3
    } tgd_cmd_t;

    typedef enum logic {
        GESTURE_SWIPE_UP   = 1'b0,
        GESTURE_LONG_PRESS = 1'b1
    } tgd_kind_t;

    typedef struct packed {
        tgd_cmd_t               cmd;
        logic [COORD_BITS-1:0]  x_pos;
        logic [COORD_BITS-1:0]  y_pos;
        logic [TIME_BITS-1:0]   time_ms;
    } tgd_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  bottom_edge_start_y;
        logic [COORD_BITS-1:0]  min_swipe_distance;
        logic [DUR_BITS-1:0]    max_swipe_duration_ms;
        logic [DUR_BITS-1:0]    long_press_duration_ms;
        logic [LP_SQ_BITS-1:0]  long_press_max_sq;
    } tgd_cfg_t;

    typedef struct packed {
        logic      valid;
        tgd_kind_t kind;
    } tgd_result_t;

endpackage

[sv/tgd_cfg_regs.sv]
// Configuration register bank with the registered square of the long-press movement limit.
module tgd_cfg_regs
    import tgd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output tgd_cfg_t                 cfg
);

    logic [COORD_BITS-1:0] bottom_edge_reg;
    logic [COORD_BITS-1:0] min_swipe_reg;
    logic [DUR_BITS-1:0]   max_swipe_dur_reg;
    logic [DUR_BITS-1:0]   lp_duration_reg;
    logic [LP_SQ_BITS-1:0] lp_sq_reg;
    logic [COORD_BITS-1:0] wr_coord;

    assign wr_coord = wr_data[COORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_edge_reg   <= RST_BOTTOM_EDGE_Y;
            min_swipe_reg     <= RST_MIN_SWIPE_DIST;
            max_swipe_dur_reg <= RST_MAX_SWIPE_DUR;
            lp_duration_reg   <= RST_LP_DURATION;
            lp_sq_reg         <= LP_SQ_BITS'(RST_LP_MAX_MOVE) * LP_SQ_BITS'(RST_LP_MAX_MOVE);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_BOTTOM_EDGE_Y:  bottom_edge_reg   <= wr_coord;
                CFG_MIN_SWIPE_DIST: min_swipe_reg     <= wr_coord;
                CFG_MAX_SWIPE_DUR:  max_swipe_dur_reg <= wr_data[DUR_BITS-1:0];
                CFG_LP_MAX_MOVE:    lp_sq_reg         <= LP_SQ_BITS'(wr_coord)
                                                         * LP_SQ_BITS'(wr_coord);
                CFG_LP_DURATION:    lp_duration_reg   <= wr_data[DUR_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.bottom_edge_start_y    = bottom_edge_reg;
    assign cfg.min_swipe_distance     = min_swipe_reg;
    assign cfg.max_swipe_duration_ms  = max_swipe_dur_reg;
    assign cfg.long_press_duration_ms = lp_duration_reg;
    assign cfg.long_press_max_sq      = lp_sq_reg;

endmodule

[sv/tgd_engine.sv]
// Touch state registers and the single-pass gesture decision logic.
module tgd_engine
    import tgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  tgd_item_t   item,
    input  tgd_cfg_t    cfg,
    output tgd_result_t result
);

    logic                         active_reg, active_next;
    logic                         taken_reg, taken_next;
    logic                         bottom_reg, bottom_next;
    logic [COORD_BITS-1:0]        start_x_reg, start_x_next;
    logic [COORD_BITS-1:0]        start_y_reg, start_y_next;
    logic [SQ_BITS-1:0]           max_sq_reg, max_sq_next;
    logic [TIME_BITS-1:0]         start_time_reg, start_time_next;

    logic signed [COORD_BITS:0]     dx, dy, up;
    logic signed [2*COORD_BITS+1:0] dx_sq, dy_sq;
    logic [SQ_BITS-1:0]             move_sq, new_max;
    logic [TIME_BITS-1:0]           elapsed;
    logic                           live, swipe_ok, time_held, press_new, press_old;

    assign dx      = $signed({1'b0, item.x_pos}) - $signed({1'b0, start_x_reg});
    assign dy      = $signed({1'b0, item.y_pos}) - $signed({1'b0, start_y_reg});
    assign up      = $signed({1'b0, start_y_reg}) - $signed({1'b0, item.y_pos});
    assign dx_sq   = dx * dx;
    assign dy_sq   = dy * dy;
    assign move_sq = dx_sq[SQ_BITS-1:0] + dy_sq[SQ_BITS-1:0];
    assign new_max = (move_sq > max_sq_reg) ? move_sq : max_sq_reg;
    assign elapsed = item.time_ms - start_time_reg;
    assign live    = active_reg && !taken_reg;

    assign swipe_ok  = bottom_reg
                       && (up >= $signed({1'b0, cfg.min_swipe_distance}))
                       && (elapsed <= TIME_BITS'(cfg.max_swipe_duration_ms));
    assign time_held = elapsed >= TIME_BITS'(cfg.long_press_duration_ms);
    assign press_new = bottom_reg && time_held
                       && (new_max <= SQ_BITS'(cfg.long_press_max_sq));
    assign press_old = bottom_reg && time_held
                       && (max_sq_reg <= SQ_BITS'(cfg.long_press_max_sq));

    always_comb
    begin
        active_next     = active_reg;
        taken_next      = taken_reg;
        bottom_next     = bottom_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        max_sq_next     = max_sq_reg;
        start_time_next = start_time_reg;
        result.valid    = 1'b0;
        result.kind     = GESTURE_SWIPE_UP;
        unique case (item.cmd)
            CMD_DOWN:
            begin
                active_next     = 1'b1;
                taken_next      = 1'b0;
                bottom_next     = item.y_pos >= cfg.bottom_edge_start_y;
                start_x_next    = item.x_pos;
                start_y_next    = item.y_pos;
                max_sq_next     = '0;
                start_time_next = item.time_ms;
            end
            CMD_MOVE:
            begin
                if (live)
                begin
                    max_sq_next = new_max;
                    priority if (swipe_ok)
                    begin
                        result.valid = 1'b1;
                        taken_next   = 1'b1;
                    end
                    else if (press_new)
                    begin
                        result.valid = 1'b1;
                        result.kind  = GESTURE_LONG_PRESS;
                        taken_next   = 1'b1;
                    end
                end
            end
            CMD_UP:
            begin
                if (live)
                begin
                    max_sq_next = new_max;
                    if (swipe_ok)
                    begin
                        result.valid = 1'b1;
                        taken_next   = 1'b1;
                    end
                end
                active_next = 1'b0;
            end
            CMD_POLL:
            begin
                if (live && press_old)
                begin
                    result.valid = 1'b1;
                    result.kind  = GESTURE_LONG_PRESS;
                    taken_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            taken_reg      <= 1'b0;
            bottom_reg     <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            max_sq_reg     <= '0;
            start_time_reg <= '0;
        end
        else if (step)
        begin
            active_reg     <= active_next;
            taken_reg      <= taken_next;
            bottom_reg     <= bottom_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            max_sq_reg     <= max_sq_next;
            start_time_reg <= start_time_next;
        end
    end

endmodule

[sv/touch_gesture_detector.sv]
// Top level of the touch gesture detector: input stage, engine and result register.
//
// Takes one touch event or time poll per clock unless a stalled result holds the input,
// and reports at most one swipe-up or long-press result per touch. An event is
// transferred into the input register, decided against the touch state once the result
// register is empty or being taken, and then registered into the result register, from
// which it is offered. Input and result registers are separate, so a waiting result
// stalls the input only when the result register is full and not being taken.
// Configuration writes take effect on the next cycle and are accepted in every cycle;
// write them only while no event is in flight.
module touch_gesture_detector
    import tgd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // x_pos, y_pos, time_ms
    input  logic [1:0]               s_axis_tuser,  // cmd
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // gesture_time_ms
    output logic                     m_axis_tuser,  // gesture_kind
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                 in_valid_reg;
    tgd_item_t            in_item_reg;
    logic                 out_valid_reg;
    tgd_kind_t            out_kind_reg;
    logic [TIME_BITS-1:0] out_time_reg;
    logic                 advance;
    tgd_cfg_t             cfg;
    tgd_result_t          result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    tgd_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tgd_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.cmd     <= tgd_cmd_t'(s_axis_tuser);
            in_item_reg.x_pos   <= s_axis_tdata[COORD_BITS-1:0];
            in_item_reg.y_pos   <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            in_item_reg.time_ms <= s_axis_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_kind_reg <= result.kind;
            out_time_reg <= in_item_reg.time_ms;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_time_reg);
    assign m_axis_tuser  = out_kind_reg;

endmodule

[sv/tgd_checker.sv]
// Port-level assertions for the touch gesture detector and their bind.
module tgd_checker
    import tgd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                     m_axis_tuser
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a matching input transfer");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while result register could move");

endmodule

bind touch_gesture_detector tgd_checker u_tgd_checker (.*);
